### hw/rtl/mhjs_pkg.sv
// Shared types, sizes and the heap ordering function for the min-heap job scheduler.
// No dependencies.
package mhjs_pkg;

	localparam int MAX_WORKERS = 256;
	localparam int ADDR_W      = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
	localparam int CIDX_W      = ADDR_W + 2;
	localparam int CNT_W       = $clog2(MAX_WORKERS + 1);
	localparam int CFG_W       = 9;
	localparam int WID_W       = 8;
	localparam int TIME_W      = 64;
	localparam int DUR_W       = 32;

	typedef struct packed {
		logic [TIME_W-1:0] free_time;
		logic [WID_W-1:0]  worker;
	} entry_t;

	typedef struct packed {
		logic [ADDR_W-1:0] rd_addr_l;
		logic [ADDR_W-1:0] rd_addr_r;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		entry_t            wr_data;
		logic              clr;
	} mem_req_t;

	typedef struct packed {
		entry_t left;
		entry_t right;
	} mem_rsp_t;

	typedef struct packed {
		logic [WID_W-1:0]  worker;
		logic [TIME_W-1:0] start;
	} res_t;

	// a orders before b by (free time, worker index)
	function automatic logic entry_less(entry_t a, entry_t b);
		logic lt;
		if (a.free_time != b.free_time) begin
			lt = a.free_time < b.free_time;
		end else begin
			lt = a.worker < b.worker;
		end
		return lt;
	endfunction

endpackage

### hw/rtl/min_heap_job_scheduler_top.sv
// Min-heap job scheduler top level: worker count register, sift sequencer,
// heap memory and result queue. Depends on mhjs_pkg and the mhjs_* modules.
//
// Usage:
//   Input channel (in_valid / in_stall / job_duration): one job per item.
//   Output channel (out_valid / out_stall / assigned_worker / start_time):
//   exactly one result per job, in order. The job goes to the worker with the
//   earliest free time, lower index on ties; its finish time saturates at 2^64-1.
//   The result is pushed into the result queue as the job is accepted and is
//   offered the cycle after if the queue was empty. After an accept, in_stall
//   stays high while the new root sinks through the heap: a memory read then a
//   compare/write per level descended, plus a last read or read/compare to finish.
//   A two-entry result queue lets jobs be taken while a result waits; in_stall
//   also rises while that queue is full.
//   cfg_we/cfg_wdata write worker_count (0 acts as 1, above 256 as 256) and
//   make all workers free at time 0. Write it only while the block is idle.
//   Reset (arst_n low): worker_count is 256, all workers free at time 0,
//   result queue empty. No clearing pass; the block is ready right away.
module min_heap_job_scheduler_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [mhjs_pkg::DUR_W-1:0]    job_duration,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mhjs_pkg::WID_W-1:0]    assigned_worker,
	output logic [mhjs_pkg::TIME_W-1:0]   start_time,
	input  logic                          cfg_we,
	input  logic [mhjs_pkg::CFG_W-1:0]    cfg_wdata
);

	logic [mhjs_pkg::CNT_W-1:0] worker_n_q;
	logic busy, full, go;
	mhjs_pkg::entry_t top;
	mhjs_pkg::mem_req_t req;
	mhjs_pkg::mem_rsp_t rsp;
	mhjs_pkg::res_t res, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			worker_n_q <= mhjs_pkg::CNT_W'(mhjs_pkg::MAX_WORKERS);
		end else if (cfg_we) begin
			if (cfg_wdata == '0) begin
				worker_n_q <= mhjs_pkg::CNT_W'(1);
			end else if (int'(cfg_wdata) > mhjs_pkg::MAX_WORKERS) begin
				worker_n_q <= mhjs_pkg::CNT_W'(mhjs_pkg::MAX_WORKERS);
			end else begin
				worker_n_q <= mhjs_pkg::CNT_W'(cfg_wdata);
			end
		end
	end

	assign in_stall = busy || full;
	assign go       = in_valid && !in_stall;
	assign res      = '{worker: top.worker, start: top.free_time};

	mhjs_sift_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.go           (go),
		.job_duration (job_duration),
		.worker_n     (worker_n_q),
		.clr          (cfg_we),
		.busy         (busy),
		.top          (top),
		.req          (req),
		.rsp          (rsp)
	);

	mhjs_heap_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	mhjs_out_buf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (go),
		.push_data (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.head      (head),
		.full      (full)
	);

	assign assigned_worker = head.worker;
	assign start_time      = head.start;

endmodule

### hw/rtl/mhjs_heap_mem.sv
// Heap storage: one write port, two registered read ports, per-entry valid bits.
// An entry never written since the last clear reads as (time 0, worker = its index).
// Depends on mhjs_pkg.
module mhjs_heap_mem (
	input  logic              clk,
	input  logic              arst_n,
	input  mhjs_pkg::mem_req_t req,
	output mhjs_pkg::mem_rsp_t rsp
);

	mhjs_pkg::entry_t mem_q [mhjs_pkg::MAX_WORKERS];
	logic [mhjs_pkg::MAX_WORKERS-1:0] vld_q;
	mhjs_pkg::entry_t rd_l_q, rd_r_q;
	logic vl_q, vr_q;
	logic [mhjs_pkg::ADDR_W-1:0] al_q, ar_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		rd_l_q <= mem_q[req.rd_addr_l];
		rd_r_q <= mem_q[req.rd_addr_r];
		al_q   <= req.rd_addr_l;
		ar_q   <= req.rd_addr_r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			vl_q  <= 1'b0;
			vr_q  <= 1'b0;
		end else begin
			vl_q <= vld_q[req.rd_addr_l];
			vr_q <= vld_q[req.rd_addr_r];
			if (req.clr) begin
				vld_q <= '0;
			end else if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
		end
	end

	always_comb begin
		rsp.left  = vl_q ? rd_l_q : '{free_time: '0, worker: mhjs_pkg::WID_W'(al_q)};
		rsp.right = vr_q ? rd_r_q : '{free_time: '0, worker: mhjs_pkg::WID_W'(ar_q)};
	end

endmodule

### hw/rtl/mhjs_sift_ctrl.sv
// Sift-down sequencer: holds the heap root, updates it per item and sinks it
// one level per read/compare pair through mhjs_heap_mem. Depends on mhjs_pkg.
module mhjs_sift_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         go,
	input  logic [mhjs_pkg::DUR_W-1:0]   job_duration,
	input  logic [mhjs_pkg::CNT_W-1:0]   worker_n,
	input  logic                         clr,
	output logic                         busy,
	output mhjs_pkg::entry_t             top,
	output mhjs_pkg::mem_req_t           req,
	input  mhjs_pkg::mem_rsp_t           rsp
);

	typedef enum logic [1:0] {ST_IDLE, ST_RD, ST_CMP} state_t;

	state_t state_q;
	logic [mhjs_pkg::ADDR_W-1:0] pos_q;
	mhjs_pkg::entry_t x_q, top_q;
	logic r_ok_q;

	logic [mhjs_pkg::CIDX_W-1:0] lidx, ridx, n_ext;
	logic leaf, use_r, sink;
	mhjs_pkg::entry_t c, wdata;
	logic [mhjs_pkg::ADDR_W-1:0] cidx;
	logic [mhjs_pkg::TIME_W:0] sum;
	logic [mhjs_pkg::TIME_W-1:0] fin;

	always_comb begin
		lidx  = {1'b0, pos_q, 1'b1};
		ridx  = lidx + mhjs_pkg::CIDX_W'(1);
		n_ext = mhjs_pkg::CIDX_W'(worker_n);
		leaf  = lidx >= n_ext;
		use_r = r_ok_q && mhjs_pkg::entry_less(rsp.right, rsp.left);
		c     = use_r ? rsp.right : rsp.left;
		cidx  = use_r ? ridx[mhjs_pkg::ADDR_W-1:0] : lidx[mhjs_pkg::ADDR_W-1:0];
		sink  = mhjs_pkg::entry_less(c, x_q);
		wdata = (state_q == ST_CMP && sink) ? c : x_q;
		sum   = {1'b0, top_q.free_time} + (mhjs_pkg::TIME_W+1)'(job_duration);
		fin   = sum[mhjs_pkg::TIME_W] ? '1 : sum[mhjs_pkg::TIME_W-1:0];

		req.rd_addr_l = lidx[mhjs_pkg::ADDR_W-1:0];
		req.rd_addr_r = ridx[mhjs_pkg::ADDR_W-1:0];
		req.wr_en     = ((state_q == ST_RD && leaf) || state_q == ST_CMP) && (pos_q != '0);
		req.wr_addr   = pos_q;
		req.wr_data   = wdata;
		req.clr       = clr;
	end

	assign busy = (state_q != ST_IDLE);
	assign top  = top_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
			x_q     <= '0;
			top_q   <= '0;
			r_ok_q  <= 1'b0;
		end else if (clr) begin
			state_q <= ST_IDLE;
			top_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (go) begin
						x_q     <= '{free_time: fin, worker: top_q.worker};
						pos_q   <= '0;
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					if (leaf) begin
						if (pos_q == '0) begin
							top_q <= x_q;
						end
						state_q <= ST_IDLE;
					end else begin
						r_ok_q  <= ridx < n_ext;
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (pos_q == '0) begin
						top_q <= wdata;
					end
					if (sink) begin
						pos_q   <= cidx;
						state_q <= ST_RD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### hw/rtl/mhjs_out_buf.sv
// Two-entry result queue between the scheduler and the output channel.
// Depends on mhjs_pkg.
module mhjs_out_buf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mhjs_pkg::res_t  push_data,
	input  logic            out_stall,
	output logic            out_valid,
	output mhjs_pkg::res_t  head,
	output logic            full
);

	logic [1:0] cnt_q;
	mhjs_pkg::res_t slot0_q, slot1_q;
	logic take;

	assign out_valid = (cnt_q != 2'd0);
	assign full      = (cnt_q == 2'd2);
	assign take      = out_valid && !out_stall;
	assign head      = slot0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			case ({push, take})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			slot0_q <= (cnt_q == 2'd2) ? slot1_q : push_data;
		end else if (push && cnt_q == 2'd0) begin
			slot0_q <= push_data;
		end
		if (push && !take && cnt_q == 2'd1) begin
			slot1_q <= push_data;
		end
	end

endmodule

### hw/rtl/mhjs_checker.sv
// Port-level checks for min_heap_job_scheduler_top, bound to every instance.
// Depends on mhjs_pkg.
module mhjs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic [mhjs_pkg::DUR_W-1:0]    job_duration,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [mhjs_pkg::WID_W-1:0]    assigned_worker,
	input logic [mhjs_pkg::TIME_W-1:0]   start_time,
	input logic                          cfg_we,
	input logic [mhjs_pkg::CFG_W-1:0]    cfg_wdata
);

	// a result is offered right after each accepted item
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> out_valid)
		else $error("no result after accepted item");

	// one item in flight: input stalls while the heap is updated
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("item accepted during heap update");

	// no result appears without an accepted item
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall))
		else $error("result without an item");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
			(out_valid && $stable(start_time) && $stable(assigned_worker)))
		else $error("stalled result changed");

endmodule

bind min_heap_job_scheduler_top mhjs_checker u_mhjs_checker (.*);

### bench/tb_min_heap_job_scheduler_top.sv
// Testbench for min_heap_job_scheduler_top: drives job durations and worker counts and
// checks every worker/start-time result against an in-bench min-heap predictor.
// Depends on mhjs_pkg and the scheduler RTL.
module tb_min_heap_job_scheduler_top;

	localparam int CYCLE_LIMIT = 600000;

	logic                              clk;
	logic                              arst_n       = 1'b0;
	logic                              in_valid     = 1'b0;
	logic                              in_stall;
	logic [mhjs_pkg::DUR_W-1:0]        job_duration = '0;
	logic                              out_valid;
	logic                              out_stall    = 1'b0;
	logic [mhjs_pkg::WID_W-1:0]        assigned_worker;
	logic [mhjs_pkg::TIME_W-1:0]       start_time;
	logic                              cfg_we       = 1'b0;
	logic [mhjs_pkg::CFG_W-1:0]        cfg_wdata    = '0;

	// predicted heap: worker ids and free times, ordered by (free time, worker)
	logic [mhjs_pkg::WID_W-1:0]        heap_ids [mhjs_pkg::MAX_WORKERS];
	logic [mhjs_pkg::TIME_W-1:0]       heap_free[mhjs_pkg::MAX_WORKERS];
	int                                live_workers;

	mhjs_pkg::res_t                    pending_assignments[$];
	int                                errors = 0;
	int                                cycles = 0;
	bit                                no_idle = 1'b0;

	min_heap_job_scheduler_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.job_duration    (job_duration),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.assigned_worker (assigned_worker),
		.start_time      (start_time),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void load_worker_count(input logic [mhjs_pkg::CFG_W-1:0] value);
		int n;
		n = int'(value);
		if (n < 1) n = 1;
		if (n > mhjs_pkg::MAX_WORKERS) n = mhjs_pkg::MAX_WORKERS;
		live_workers = n;
		for (int i = 0; i < mhjs_pkg::MAX_WORKERS; i++) begin
			heap_ids[i]  = mhjs_pkg::WID_W'(i);
			heap_free[i] = '0;
		end
	endfunction

	function automatic bit runs_first(input int a, input int b);
		if (heap_free[a] != heap_free[b]) return heap_free[a] < heap_free[b];
		return heap_ids[a] < heap_ids[b];
	endfunction

	function automatic mhjs_pkg::res_t assign_job(input logic [mhjs_pkg::DUR_W-1:0] dur);
		mhjs_pkg::res_t              r;
		logic [mhjs_pkg::TIME_W:0]   finish;
		int                          pos;
		int                          best;
		int                          lc;
		logic [mhjs_pkg::WID_W-1:0]  tid;
		logic [mhjs_pkg::TIME_W-1:0] tt;
		r.worker = heap_ids[0];
		r.start  = heap_free[0];
		finish = {1'b0, heap_free[0]} + (mhjs_pkg::TIME_W+1)'(dur);
		heap_free[0] = finish[mhjs_pkg::TIME_W] ? {mhjs_pkg::TIME_W{1'b1}}
			: finish[mhjs_pkg::TIME_W-1:0];
		pos = 0;
		forever begin
			best = pos;
			lc = 2 * pos + 1;
			if (lc < live_workers && runs_first(lc, best)) best = lc;
			if (lc + 1 < live_workers && runs_first(lc + 1, best)) best = lc + 1;
			if (best == pos) break;
			tid = heap_ids[pos];
			tt  = heap_free[pos];
			heap_ids[pos]   = heap_ids[best];
			heap_free[pos]  = heap_free[best];
			heap_ids[best]  = tid;
			heap_free[best] = tt;
			pos = best;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH cycle %0d: %s", cycles, msg);
		errors++;
	endtask

	task automatic add_expected(input mhjs_pkg::res_t r);
		pending_assignments.insert(pending_assignments.size(), r);
	endtask

	// mostly short jobs so free times tie often, some wide ones for carries
	function automatic logic [mhjs_pkg::DUR_W-1:0] pick_duration();
		int r;
		r = $urandom_range(9);
		if (r < 4) return mhjs_pkg::DUR_W'($urandom_range(3));
		if (r < 7) return mhjs_pkg::DUR_W'($urandom_range(1000));
		return mhjs_pkg::DUR_W'($urandom);
	endfunction

	task automatic send_job(input logic [mhjs_pkg::DUR_W-1:0] dur);
		while (!no_idle && $urandom_range(99) < 23) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		job_duration <= dur;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		add_expected(assign_job(dur));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_assignments.size() != 0) @(posedge clk);
		// let the last sift finish
		repeat (24) @(posedge clk);
	endtask

	task automatic write_worker_count(input logic [mhjs_pkg::CFG_W-1:0] value);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		load_worker_count(value);
	endtask

	task automatic test_directed();
		// reset state: 256 workers, all free at 0
		send_job(32'h0000_0000);
		send_job(32'hFFFF_FFFF);
		send_job(32'h0000_0001);
		send_job(32'hAAAA_AAAA);
		send_job(32'h5555_5555);
		// zero acts as one worker; start times carry past 32 bits
		write_worker_count(9'd0);
		send_job(32'hFFFF_FFFF);
		send_job(32'hFFFF_FFFF);
		send_job(32'h0000_0000);
		send_job(32'h0000_0007);
		write_worker_count(9'd1);
		send_job(32'h8000_0000);
		send_job(32'h0000_0003);
		// two workers, equal free times
		write_worker_count(9'd2);
		send_job(32'd5);
		send_job(32'd5);
		send_job(32'd3);
		send_job(32'd0);
		send_job(32'd2);
		// above the bound saturates to 256
		write_worker_count(9'h1FF);
		send_job(32'd0);
		send_job(32'd0);
		write_worker_count(9'd257);
		send_job(32'd1);
		write_worker_count(9'd3);
		send_job(32'd3);
		send_job(32'd1);
		send_job(32'd1);
	endtask

	task automatic test_back_to_back();
		write_worker_count(9'd7);
		no_idle = 1'b1;
		repeat (150) send_job(pick_duration());
		wait_idle();
		no_idle = 1'b0;
	endtask

	task automatic test_full_heap();
		write_worker_count(9'd256);
		repeat (400)
			send_job(mhjs_pkg::DUR_W'($urandom_range(1) ? $urandom_range(3) : $urandom));
	endtask

	task automatic test_random_phases();
		int                         sent;
		int                         jobs;
		logic [mhjs_pkg::CFG_W-1:0] count;
		sent = 0;
		while (sent < 700) begin
			case ($urandom_range(7))
				0:       count = mhjs_pkg::CFG_W'($urandom);
				1:       count = 9'd256;
				default: count = mhjs_pkg::CFG_W'($urandom_range(1, 40));
			endcase
			jobs = (count > 40) ? $urandom_range(60, 200) : $urandom_range(20, 80);
			write_worker_count(count);
			repeat (jobs) send_job(pick_duration());
			sent += jobs;
		end
	endtask

	always @(posedge clk) begin
		out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 23);
	end

	always @(posedge clk) begin
		mhjs_pkg::res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_assignments.size() == 0) begin
				report_mismatch($sformatf("unexpected result worker %0d start %0d",
					assigned_worker, start_time));
			end else begin
				want = pending_assignments.pop_front();
				if (assigned_worker !== want.worker)
					report_mismatch($sformatf("assigned_worker %0d, want %0d",
						assigned_worker, want.worker));
				if (start_time !== want.start)
					report_mismatch($sformatf("start_time %0d, want %0d",
						start_time, want.start));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		load_worker_count(9'd256);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_back_to_back();
		test_full_heap();
		test_random_phases();
		wait_idle();
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

### files.f
hw/rtl/mhjs_pkg.sv
hw/rtl/mhjs_heap_mem.sv
hw/rtl/mhjs_sift_ctrl.sv
hw/rtl/mhjs_out_buf.sv
hw/rtl/min_heap_job_scheduler_top.sv
hw/rtl/mhjs_checker.sv
bench/tb_min_heap_job_scheduler_top.sv
